// ===== hdl/rx_byte_fifo_with_line_fetch_macros.svh =====
// Assertion macros used by the receive FIFO datapath.
// Each macro checks a property on the rising clock edge, disabled while in reset.
`ifndef RX_BYTE_FIFO_WITH_LINE_FETCH_MACROS_SVH
`define RX_BYTE_FIFO_WITH_LINE_FETCH_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define RBF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its condition.
`define RBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rbf_pkg.sv =====
// Shared types and constants for the receive byte FIFO with line fetch.
// No dependencies; every other file but the macro header takes its names by package scope.
`timescale 1ns / 1ps

package rbf_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int OP_W        = 3;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int FILL_W      = 6;
  localparam int MAX_RESULTS = 32;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_FIND  = 3'd2,
    OP_LINE  = 3'd3,
    OP_CLEAR = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LINE_RD,
    S_LINE_EMIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_PUSH,
    RES_FIND,
    RES_BYTE
  } res_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      do_push;
    logic      do_clear;
    logic      scan_start;
    logic      scan_step;
    logic      pop_step;
    logic      load_res;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            len_small;
    logic            scan_hit;
    logic            scan_miss;
    logic            res_last;
  } dp_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              found;
    logic              accepted;
    logic [FILL_W-1:0] fill_level;
    logic              is_full;
    logic              is_empty;
    logic              last;
  } rsp_t;

endpackage

// ===== hdl/rbf_ifs.sv =====
// Valid/ready channel interfaces for FIFO requests and results.
// Depends on rbf_pkg for field widths.
`timescale 1ns / 1ps

interface rbf_req_if;
  logic                        valid;
  logic                        ready;
  logic [rbf_pkg::OP_W-1:0]    opcode;
  logic [rbf_pkg::BYTE_W-1:0]  data_byte;
  logic [rbf_pkg::BYTE_W-1:0]  search_byte;
  logic [rbf_pkg::LEN_W-1:0]   max_length;

  modport source (output valid, opcode, data_byte, search_byte, max_length, input ready);
  modport sink (input valid, opcode, data_byte, search_byte, max_length, output ready);
endinterface

interface rbf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rbf_pkg::BYTE_W-1:0]  out_byte;
  logic [rbf_pkg::LEN_W-1:0]   line_length;
  logic                        found;
  logic                        accepted;
  logic [rbf_pkg::FILL_W-1:0]  fill_level;
  logic                        is_full;
  logic                        is_empty;
  logic                        last;

  modport source (output valid, out_byte, line_length, found, accepted, fill_level,
                  is_full, is_empty, last, input ready);
  modport sink (input valid, out_byte, line_length, found, accepted, fill_level,
                is_full, is_empty, last, output ready);
endinterface

// ===== hdl/rbf_datapath.sv =====
// Datapath of the receive FIFO: byte memory, pointers, scan walker and result register.
// Depends on rbf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rx_byte_fifo_with_line_fetch_macros.svh"

module rbf_datapath #(
  parameter int DEPTH = rbf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rbf_pkg::dp_cmd_t            cmd,
  output rbf_pkg::dp_stat_t           stat,
  input  logic [rbf_pkg::OP_W-1:0]    opcode,
  input  logic [rbf_pkg::BYTE_W-1:0]  data_byte,
  input  logic [rbf_pkg::BYTE_W-1:0]  search_byte,
  input  logic [rbf_pkg::LEN_W-1:0]   max_length,
  output rbf_pkg::rsp_t               res
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Byte store and its registered read port.
  logic [rbf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [rbf_pkg::BYTE_W-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;

  // Latched request fields.
  logic [rbf_pkg::OP_W-1:0]   op;
  logic [rbf_pkg::BYTE_W-1:0] data;
  logic [rbf_pkg::BYTE_W-1:0] key;
  logic [rbf_pkg::LEN_W-1:0]  max_len;

  // FIFO state.
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Scan walker and line pop counter.
  logic [IDX_W-1:0]          scan_pos;
  logic [CNT_W-1:0]          scan_left;
  logic                      cmp_valid;
  logic                      pop_vld;
  logic [rbf_pkg::LEN_W-1:0] pop_cnt;

  logic                       full;
  logic                       empty;
  logic                       do_write;
  logic                       do_pop;
  logic [rbf_pkg::BYTE_W-1:0] key_sel;
  logic [rbf_pkg::BYTE_W-1:0] pop_byte;
  logic [rbf_pkg::LEN_W-1:0]  limit;
  logic [7:0]                 count_wide;
  rbf_pkg::rsp_t              res_next;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_write = cmd.do_push && !full;
  assign do_pop   = cmd.pop_step && !empty;
  assign key_sel  = (op == rbf_pkg::OP_LINE) ? rbf_pkg::NEWLINE : key;
  assign pop_byte = pop_vld ? rd_data : '0;

  // Pop limit is max_length minus one, capped at the result count limit.
  assign limit = (max_len > rbf_pkg::LEN_W'(rbf_pkg::MAX_RESULTS + 1)) ?
                 rbf_pkg::LEN_W'(rbf_pkg::MAX_RESULTS) : max_len - 1'b1;

  // Fill count after this cycle's update.
  always_comb begin
    count_next = count;
    if (cmd.do_clear) begin
      count_next = '0;
    end else if (do_write) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op      <= opcode;
      data    <= data_byte;
      key     <= search_byte;
      max_len <= max_length;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (cmd.do_clear) begin
        wr_idx <= '0;
        rd_idx <= '0;
      end else begin
        if (do_write) begin
          wr_idx <= wrap_inc(wr_idx);
        end
        if (do_pop) begin
          rd_idx <= wrap_inc(rd_idx);
        end
      end
    end
  end

  // Memory write and registered read; the scan walker owns the read port while stepping.
  assign rd_addr = cmd.scan_step ? scan_pos : rd_idx;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_idx] <= data;
    end
    rd_data <= mem[rd_addr];
  end

  // Scan walker: one read issued per cycle, compared in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos  <= '0;
      scan_left <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_pos  <= rd_idx;
      scan_left <= count;
      cmp_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_left != '0) begin
        scan_pos  <= wrap_inc(scan_pos);
        scan_left <= scan_left - 1'b1;
        cmp_valid <= 1'b1;
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  // Pop tracking for pop and line fetch.
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_vld <= 1'b0;
      pop_cnt <= '0;
    end else if (cmd.load_in) begin
      pop_vld <= 1'b0;
      pop_cnt <= '0;
    end else if (cmd.pop_step) begin
      pop_vld <= !empty;
      pop_cnt <= pop_cnt + 1'b1;
    end
  end

  // Result formation.
  assign count_wide = 8'(count_next);

  always_comb begin
    res_next             = '0;
    res_next.fill_level  = count_wide[rbf_pkg::FILL_W-1:0];
    res_next.is_full     = (count_next == FULL_CNT);
    res_next.is_empty    = (count_next == '0);
    res_next.last        = 1'b1;
    case (cmd.res_kind)
      rbf_pkg::RES_PUSH: begin
        res_next.accepted = !full;
      end
      rbf_pkg::RES_FIND: begin
        res_next.found = stat.scan_hit;
      end
      rbf_pkg::RES_BYTE: begin
        res_next.out_byte = pop_byte;
        if (op == rbf_pkg::OP_LINE) begin
          res_next.line_length = pop_cnt;
          res_next.last        = (pop_byte == rbf_pkg::NEWLINE) || (pop_cnt == limit);
        end
      end
      default: begin
        res_next.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res <= res_next;
    end
  end

  // Status to the controller.
  always_comb begin
    stat           = '0;
    stat.op        = op;
    stat.empty     = empty;
    stat.full      = full;
    stat.len_small = (max_len <= rbf_pkg::LEN_W'(1));
    stat.scan_hit  = cmp_valid && (rd_data == key_sel);
    stat.scan_miss = (scan_left == '0) && !cmp_valid;
    stat.res_last  = res.last;
  end

  `RBF_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT, "fill count above depth")
  `RBF_ASSERT_NEXT(a_pop_dec, clk, rst, cmd.pop_step && !empty && !cmd.do_clear, count == $past(count) - 1'b1, "pop did not reduce fill count")
  `RBF_ASSERT_NEXT(a_full_drop, clk, rst, cmd.do_push && full, $stable(count) && $stable(wr_idx), "push into full FIFO changed state")

endmodule

// ===== hdl/rbf_ctrl.sv =====
// Controller state machine of the receive FIFO; sequences the datapath per request.
// Depends on rbf_pkg for the state, command and status types.
`timescale 1ns / 1ps

module rbf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  rbf_pkg::dp_stat_t stat,
  output rbf_pkg::dp_cmd_t  cmd
);

  rbf_pkg::state_t state;
  rbf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rbf_pkg::S_IDLE: begin
        if (req_valid) state_next = rbf_pkg::S_DECODE;
      end
      rbf_pkg::S_DECODE: begin
        case (stat.op)
          rbf_pkg::OP_POP: state_next = rbf_pkg::S_LINE_RD;
          rbf_pkg::OP_FIND: state_next = rbf_pkg::S_SCAN;
          rbf_pkg::OP_LINE: begin
            if (stat.empty || stat.len_small) begin
              state_next = rbf_pkg::S_OUT;
            end else if (stat.full) begin
              state_next = rbf_pkg::S_LINE_RD;
            end else begin
              state_next = rbf_pkg::S_SCAN;
            end
          end
          default: state_next = rbf_pkg::S_OUT;
        endcase
      end
      rbf_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          state_next = (stat.op == rbf_pkg::OP_FIND) ? rbf_pkg::S_OUT : rbf_pkg::S_LINE_RD;
        end else if (stat.scan_miss) begin
          state_next = rbf_pkg::S_OUT;
        end
      end
      rbf_pkg::S_LINE_RD: state_next = rbf_pkg::S_LINE_EMIT;
      rbf_pkg::S_LINE_EMIT: state_next = rbf_pkg::S_OUT;
      rbf_pkg::S_OUT: begin
        if (rsp_ready) begin
          state_next = stat.res_last ? rbf_pkg::S_IDLE : rbf_pkg::S_LINE_RD;
        end
      end
      default: state_next = rbf_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd          = '0;
    cmd.res_kind = rbf_pkg::RES_PLAIN;
    req_ready    = 1'b0;
    rsp_valid    = 1'b0;
    case (state)
      rbf_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cmd.load_in = req_valid;
      end
      rbf_pkg::S_DECODE: begin
        case (stat.op)
          rbf_pkg::OP_PUSH: begin
            cmd.do_push  = 1'b1;
            cmd.load_res = 1'b1;
            cmd.res_kind = rbf_pkg::RES_PUSH;
          end
          rbf_pkg::OP_POP: begin
            cmd.load_res = 1'b0;
          end
          rbf_pkg::OP_FIND: begin
            cmd.scan_start = 1'b1;
          end
          rbf_pkg::OP_LINE: begin
            if (stat.empty || stat.len_small) begin
              cmd.load_res = 1'b1;
            end else if (!stat.full) begin
              cmd.scan_start = 1'b1;
            end
          end
          rbf_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.load_res = 1'b1;
          end
          default: begin
            cmd.load_res = 1'b1;
          end
        endcase
      end
      rbf_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.op == rbf_pkg::OP_FIND) begin
          if (stat.scan_hit || stat.scan_miss) begin
            cmd.load_res = 1'b1;
            cmd.res_kind = rbf_pkg::RES_FIND;
          end
        end else if (!stat.scan_hit && stat.scan_miss) begin
          cmd.load_res = 1'b1;
        end
      end
      rbf_pkg::S_LINE_RD: begin
        cmd.pop_step = 1'b1;
      end
      rbf_pkg::S_LINE_EMIT: begin
        cmd.load_res = 1'b1;
        cmd.res_kind = rbf_pkg::RES_BYTE;
      end
      rbf_pkg::S_OUT: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/rx_byte_fifo_with_line_fetch.sv =====
// Push, clear and a refused get line are answered from the decode state; pop reads one byte
// through the read and emit states. Find scans the stored bytes for the search byte.
// Get line scans for a newline (skipped when full); then each popped byte goes through
// the single memory read port; one request is in flight.
// A new request is taken the cycle after the last result transaction of the previous one.
// Synchronous active-high reset empties the FIFO; the byte memory is not cleared.
`timescale 1ns / 1ps

module rx_byte_fifo_with_line_fetch #(
  parameter int DEPTH = rbf_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rbf_req_if.sink   req,
  rbf_rsp_if.source rsp
);

  rbf_pkg::dp_cmd_t  cmd;
  rbf_pkg::dp_stat_t stat;
  rbf_pkg::rsp_t     res;

  // Sequencing.
  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and result formation.
  rbf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (req.opcode),
    .data_byte   (req.data_byte),
    .search_byte (req.search_byte),
    .max_length  (req.max_length),
    .res         (res)
  );

  // Result register drives the output channel payload.
  assign rsp.out_byte    = res.out_byte;
  assign rsp.line_length = res.line_length;
  assign rsp.found       = res.found;
  assign rsp.accepted    = res.accepted;
  assign rsp.fill_level  = res.fill_level;
  assign rsp.is_full     = res.is_full;
  assign rsp.is_empty    = res.is_empty;
  assign rsp.last        = res.last;

endmodule
